// ----- hdl/igsdp_pkg.sv -----
package igsdp_pkg;

   localparam int GROUP_SIZE    = 32;
   localparam int ELEMS_CARRIED = 32;
   localparam int ELEMS_USED    = (GROUP_SIZE < ELEMS_CARRIED) ? GROUP_SIZE : ELEMS_CARRIED;
   localparam int LANES         = 8;
   localparam int DOT_STEPS     = ELEMS_CARRIED / LANES;
   localparam int STEP_W        = $clog2(DOT_STEPS);

   localparam logic [31:0] CANON_NAN = 32'h7FC00000;
   localparam logic [30:0] INF_MAG   = 31'h7F800000;

   typedef struct packed {
      logic              accept;
      logic              dot_en;
      logic [STEP_W-1:0] dot_idx;
      logic              conv_en;
      logic              mul_unp_en;
      logic              mul_sel;
      logic              mul_mult_en;
      logic              mul_rnd_en;
      logic              add_unp_en;
      logic              add_sum_en;
      logic              add_rnd_en;
      logic              emit_en;
   } cmd_type;

   typedef struct packed {
      logic last_group;
   } status_type;

endpackage

// ----- hdl/int4_group_scaled_dot_product_core.sv -----
// A new request is accepted only in idle, after the previous group has passed through
// the 4-step lane dot product, two passes through the single binary32 multiplier and
// the accumulate add (align, add, then normalize and round).
// A waiting result stalls the next last group at its final step until it is taken.
// Reset (synchronous, active high) clears the controller, the result valid flag
// and sets the accumulator to binary32 +0.0.
module int4_group_scaled_dot_product_core #(
   parameter int GROUP_SIZE = igsdp_pkg::GROUP_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_activations_a,
   input  logic [63:0] req_activations_b,
   input  logic [63:0] req_activations_c,
   input  logic [63:0] req_activations_d,
   input  logic [63:0] req_weight_nibbles_lo,
   input  logic [63:0] req_weight_nibbles_hi,
   input  logic [31:0] req_act_scale,
   input  logic [15:0] req_weight_scale,
   input  logic        req_last_group,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sum_bits
);

   igsdp_pkg::cmd_type    cmd;
   igsdp_pkg::status_type status;

   igsdp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   igsdp_datapath #(
      .GROUP_SIZE (GROUP_SIZE)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_activations_a     (req_activations_a),
      .req_activations_b     (req_activations_b),
      .req_activations_c     (req_activations_c),
      .req_activations_d     (req_activations_d),
      .req_weight_nibbles_lo (req_weight_nibbles_lo),
      .req_weight_nibbles_hi (req_weight_nibbles_hi),
      .req_act_scale         (req_act_scale),
      .req_weight_scale      (req_weight_scale),
      .req_last_group        (req_last_group),
      .rsp_sum_bits          (rsp_sum_bits)
   );

endmodule

// ----- hdl/igsdp_datapath.sv -----
module igsdp_datapath #(
   parameter int GROUP_SIZE = igsdp_pkg::GROUP_SIZE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  igsdp_pkg::cmd_type     cmd,
   output igsdp_pkg::status_type  status,
   input  logic [63:0]            req_activations_a,
   input  logic [63:0]            req_activations_b,
   input  logic [63:0]            req_activations_c,
   input  logic [63:0]            req_activations_d,
   input  logic [63:0]            req_weight_nibbles_lo,
   input  logic [63:0]            req_weight_nibbles_hi,
   input  logic [31:0]            req_act_scale,
   input  logic [15:0]            req_weight_scale,
   input  logic                   req_last_group,
   output logic [31:0]            rsp_sum_bits
);

   localparam int ELEMS_USED = (GROUP_SIZE < igsdp_pkg::ELEMS_CARRIED) ?
                               GROUP_SIZE : igsdp_pkg::ELEMS_CARRIED;

   localparam logic [1:0] SPEC_NONE = 2'd0;
   localparam logic [1:0] SPEC_ZERO = 2'd1;
   localparam logic [1:0] SPEC_INF  = 2'd2;
   localparam logic [1:0] SPEC_NAN  = 2'd3;

   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] c;
      c = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) c = 6'(31 - i);
      end
      return c;
   endfunction

   function automatic logic [31:0] fp_pack(input logic s, input logic [9:0] e_use,
                                           input logic [23:0] m, input logic g,
                                           input logic st);
      logic        up;
      logic [24:0] m25;
      logic [32:0] tot;
      up  = g & (st | m[0]);
      m25 = {1'b0, m} + 25'(up);
      tot = {e_use - 10'd1, 23'b0} + 33'(m25);
      if (tot >= {2'b00, igsdp_pkg::INF_MAG}) return {s, igsdp_pkg::INF_MAG};
      return {s, tot[30:0]};
   endfunction

   function automatic logic [33:0] mul_unpack(input logic [31:0] f);
      logic [23:0] m0;
      logic [5:0]  lz;
      m0 = {1'b0, f[22:0]};
      lz = lzc32({m0, 8'b0});
      if (f[30:23] != 8'd0) return {1'b1, f[22:0], 10'(f[30:23]) - 10'd127};
      return {m0 << lz, -10'sd126 - 10'(lz)};
   endfunction

   logic [3:0][63:0] act_ff, act_in;
   logic [1:0][63:0] wgt_ff, wgt_in;
   logic [31:0] ascale_ff, ascale_in;
   logic [15:0] wscale_ff, wscale_in;
   logic        last_ff, last_in;
   logic signed [16:0] dot_ff, dot_in;
   logic [31:0] dotf_ff, dotf_in;
   logic [31:0] wsf_ff, wsf_in;

   logic [23:0] mu_ma_ff, mu_ma_in, mu_mb_ff, mu_mb_in;
   logic signed [9:0] mu_xa_ff, mu_xa_in, mu_xb_ff, mu_xb_in;
   logic        mu_sign_ff, mu_sign_in;
   logic [1:0]  mu_spec_ff, mu_spec_in;

   logic [47:0] mm_p_ff, mm_p_in;
   logic signed [9:0] mm_x_ff, mm_x_in;
   logic        mm_sign_ff, mm_sign_in;
   logic [1:0]  mm_spec_ff, mm_spec_in;

   logic [31:0] term_ff, term_in;

   logic [26:0] au_big_ff, au_big_in, au_sm_ff, au_sm_in;
   logic [7:0]  au_ebig_ff, au_ebig_in;
   logic        au_sub_ff, au_sub_in, au_sign_ff, au_sign_in, au_zsign_ff, au_zsign_in;
   logic [1:0]  au_spec_ff, au_spec_in;

   logic [27:0] as_s_ff, as_s_in;
   logic [7:0]  as_ebig_ff, as_ebig_in;
   logic        as_sign_ff, as_sign_in, as_zsign_ff, as_zsign_in;
   logic [1:0]  as_spec_ff, as_spec_in;

   logic [31:0] acc_ff, acc_in;
   logic [31:0] rsp_ff, rsp_in;

   // request capture
   always_comb begin
      act_in    = act_ff;
      wgt_in    = wgt_ff;
      ascale_in = ascale_ff;
      wscale_in = wscale_ff;
      last_in   = last_ff;
      if (cmd.accept) begin
         act_in    = {req_activations_d, req_activations_c,
                      req_activations_b, req_activations_a};
         wgt_in    = {req_weight_nibbles_hi, req_weight_nibbles_lo};
         ascale_in = req_act_scale;
         wscale_in = req_weight_scale;
         last_in   = req_last_group;
      end
   end

   // dot product, one lane group per step
   always_comb begin
      logic signed [15:0] part;
      logic [63:0]        wsel;
      logic [63:0]        asel;
      logic signed [7:0]  a_s;
      logic [3:0]         nib;
      logic signed [4:0]  w_s;
      logic signed [12:0] p_s;
      logic [4:0]         k;
      part = '0;
      asel = act_ff[cmd.dot_idx];
      wsel = wgt_ff[cmd.dot_idx[igsdp_pkg::STEP_W-1]];
      for (int j = 0; j < igsdp_pkg::LANES; j++) begin
         k   = {cmd.dot_idx, 3'(j)};
         a_s = signed'(asel[8*j +: 8]);
         nib = wsel[{cmd.dot_idx[0], 3'(j), 2'b00} +: 4];
         w_s = signed'({1'b0, nib}) - 5'sd8;
         p_s = 13'(a_s) * 13'(w_s);
         if (int'(k) < ELEMS_USED) part = part + 16'(p_s);
      end
      dot_in = dot_ff;
      if (cmd.accept)      dot_in = '0;
      else if (cmd.dot_en) dot_in = dot_ff + 17'(part);
   end

   // integer to binary32 and binary16 widening
   always_comb begin
      logic        ds;
      logic [16:0] dmag;
      logic [15:0] dm;
      logic [15:0] dsh;
      logic [5:0]  dlz;
      logic [5:0]  hlz;
      logic [9:0]  hsh;
      logic        hs;
      logic [4:0]  he;
      logic [9:0]  hf;
      ds   = dot_ff[16];
      dmag = ds ? 17'(-dot_ff) : 17'(dot_ff);
      dm   = dmag[15:0];
      dlz  = lzc32({dm, 16'b0});
      dsh  = dm << (dlz + 6'd1);
      dotf_in = dotf_ff;
      wsf_in  = wsf_ff;
      hs = wscale_ff[15];
      he = wscale_ff[14:10];
      hf = wscale_ff[9:0];
      hlz = lzc32({hf, 22'b0});
      hsh = hf << (hlz + 6'd1);
      if (cmd.conv_en) begin
         if (dm == 16'd0) dotf_in = 32'd0;
         else dotf_in = {ds, 8'd142 - 8'(dlz), dsh, 7'b0};
         if (he == 5'd0) begin
            if (hf == 10'd0) wsf_in = {hs, 31'd0};
            else wsf_in = {hs, 8'd112 - 8'(hlz), hsh, 13'b0};
         end else if (he == 5'd31) begin
            if (hf != 10'd0) wsf_in = igsdp_pkg::CANON_NAN | {hs, 31'd0};
            else wsf_in = {hs, igsdp_pkg::INF_MAG};
         end else begin
            wsf_in = {hs, 8'(he) + 8'd112, hf, 13'b0};
         end
      end
   end

   // multiplier: unpack
   always_comb begin
      logic [31:0] a, b;
      logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
      a = cmd.mul_sel ? term_ff : dotf_ff;
      b = cmd.mul_sel ? wsf_ff : ascale_ff;
      nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      zero_a = (a[30:0] == 31'd0);
      zero_b = (b[30:0] == 31'd0);
      {mu_ma_in, mu_xa_in} = cmd.mul_unp_en ? mul_unpack(a) : {mu_ma_ff, mu_xa_ff};
      {mu_mb_in, mu_xb_in} = cmd.mul_unp_en ? mul_unpack(b) : {mu_mb_ff, mu_xb_ff};
      mu_sign_in = mu_sign_ff;
      mu_spec_in = mu_spec_ff;
      if (cmd.mul_unp_en) begin
         mu_sign_in = a[31] ^ b[31];
         if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) mu_spec_in = SPEC_NAN;
         else if (inf_a || inf_b)  mu_spec_in = SPEC_INF;
         else if (zero_a || zero_b) mu_spec_in = SPEC_ZERO;
         else mu_spec_in = SPEC_NONE;
      end
   end

   // multiplier: product
   always_comb begin
      mm_p_in    = mm_p_ff;
      mm_x_in    = mm_x_ff;
      mm_sign_in = mm_sign_ff;
      mm_spec_in = mm_spec_ff;
      if (cmd.mul_mult_en) begin
         mm_p_in    = 48'(mu_ma_ff) * 48'(mu_mb_ff);
         mm_x_in    = mu_xa_ff + mu_xb_ff;
         mm_sign_in = mu_sign_ff;
         mm_spec_in = mu_spec_ff;
      end
   end

   // multiplier: normalize and round
   always_comb begin
      logic [47:0]        n, ns;
      logic signed [9:0]  x;
      logic signed [10:0] eb;
      logic [5:0]         sh;
      logic [9:0]         e_use;
      logic               lost;
      n  = mm_p_ff[47] ? mm_p_ff : (mm_p_ff << 1);
      x  = mm_p_ff[47] ? (mm_x_ff + 10'sd1) : mm_x_ff;
      eb = 11'(x) + 11'sd127;
      if (eb > 11'sd0) begin
         sh    = 6'd0;
         e_use = eb[9:0];
      end else begin
         sh    = (eb < -11'sd62) ? 6'd63 : 6'(11'sd1 - eb);
         e_use = 10'd1;
      end
      ns   = n >> sh;
      lost = (ns << sh) != n;
      term_in = term_ff;
      if (cmd.mul_rnd_en) begin
         case (mm_spec_ff)
            SPEC_NAN:  term_in = igsdp_pkg::CANON_NAN;
            SPEC_INF:  term_in = {mm_sign_ff, igsdp_pkg::INF_MAG};
            SPEC_ZERO: term_in = {mm_sign_ff, 31'd0};
            default:   term_in = fp_pack(mm_sign_ff, e_use, ns[47:24], ns[23],
                                         (|ns[22:0]) | lost);
         endcase
      end
   end

   // adder: order and align
   always_comb begin
      logic [31:0] a, b, big, sml;
      logic [7:0]  esm, d;
      logic [4:0]  sh;
      logic [26:0] sext, sm;
      logic nan_a, nan_b, inf_a, inf_b;
      logic lost;
      a = acc_ff;
      b = term_ff;
      nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      big = (a[30:0] >= b[30:0]) ? a : b;
      sml = (a[30:0] >= b[30:0]) ? b : a;
      esm = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      au_big_in   = au_big_ff;
      au_sm_in    = au_sm_ff;
      au_ebig_in  = au_ebig_ff;
      au_sub_in   = au_sub_ff;
      au_sign_in  = au_sign_ff;
      au_zsign_in = au_zsign_ff;
      au_spec_in  = au_spec_ff;
      d    = ((big[30:23] == 8'd0) ? 8'd1 : big[30:23]) - esm;
      sh   = (d > 8'd27) ? 5'd27 : d[4:0];
      sext = {|sml[30:23], sml[22:0], 3'b000};
      sm   = sext >> sh;
      lost = (sm << sh) != sext;
      if (cmd.add_unp_en) begin
         au_big_in   = {|big[30:23], big[22:0], 3'b000};
         au_sm_in    = {sm[26:1], sm[0] | lost};
         au_ebig_in  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
         au_sub_in   = a[31] ^ b[31];
         au_sign_in  = big[31];
         au_zsign_in = a[31] & b[31];
         if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) au_spec_in = SPEC_NAN;
         else if (inf_a || inf_b) au_spec_in = SPEC_INF;
         else au_spec_in = SPEC_NONE;
      end
   end

   // adder: add or subtract
   always_comb begin
      as_s_in     = as_s_ff;
      as_ebig_in  = as_ebig_ff;
      as_sign_in  = as_sign_ff;
      as_zsign_in = as_zsign_ff;
      as_spec_in  = as_spec_ff;
      if (cmd.add_sum_en) begin
         as_s_in     = au_sub_ff ? ({1'b0, au_big_ff} - {1'b0, au_sm_ff})
                                 : ({1'b0, au_big_ff} + {1'b0, au_sm_ff});
         as_ebig_in  = au_ebig_ff;
         as_sign_in  = au_sign_ff;
         as_zsign_in = au_zsign_ff;
         as_spec_in  = au_spec_ff;
      end
   end

   // adder: normalize, round, accumulate
   always_comb begin
      logic [26:0] sn;
      logic [9:0]  e;
      logic [5:0]  lz;
      logic [7:0]  lim, shl;
      logic [31:0] sum;
      lz  = lzc32({as_s_ff[26:0], 5'b0});
      lim = as_ebig_ff - 8'd1;
      shl = (8'(lz) < lim) ? 8'(lz) : lim;
      if (as_s_ff[27]) begin
         sn = {as_s_ff[27:2], as_s_ff[1] | as_s_ff[0]};
         e  = 10'(as_ebig_ff) + 10'd1;
      end else begin
         sn = as_s_ff[26:0] << shl;
         e  = 10'(as_ebig_ff) - 10'(shl);
      end
      if (as_spec_ff == SPEC_NAN)      sum = igsdp_pkg::CANON_NAN;
      else if (as_spec_ff == SPEC_INF) sum = {as_sign_ff, igsdp_pkg::INF_MAG};
      else if (as_s_ff == 28'd0)       sum = {as_zsign_ff, 31'd0};
      else sum = fp_pack(as_sign_ff, e, sn[26:3], sn[2], |sn[1:0]);
      acc_in = acc_ff;
      rsp_in = rsp_ff;
      if (cmd.add_rnd_en) acc_in = sum;
      if (cmd.emit_en) begin
         rsp_in = acc_ff;
         acc_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      wgt_ff      <= wgt_in;
      ascale_ff   <= ascale_in;
      wscale_ff   <= wscale_in;
      last_ff     <= last_in;
      dot_ff      <= dot_in;
      dotf_ff     <= dotf_in;
      wsf_ff      <= wsf_in;
      mu_ma_ff    <= mu_ma_in;
      mu_mb_ff    <= mu_mb_in;
      mu_xa_ff    <= mu_xa_in;
      mu_xb_ff    <= mu_xb_in;
      mu_sign_ff  <= mu_sign_in;
      mu_spec_ff  <= mu_spec_in;
      mm_p_ff     <= mm_p_in;
      mm_x_ff     <= mm_x_in;
      mm_sign_ff  <= mm_sign_in;
      mm_spec_ff  <= mm_spec_in;
      term_ff     <= term_in;
      au_big_ff   <= au_big_in;
      au_sm_ff    <= au_sm_in;
      au_ebig_ff  <= au_ebig_in;
      au_sub_ff   <= au_sub_in;
      au_sign_ff  <= au_sign_in;
      au_zsign_ff <= au_zsign_in;
      au_spec_ff  <= au_spec_in;
      as_s_ff     <= as_s_in;
      as_ebig_ff  <= as_ebig_in;
      as_sign_ff  <= as_sign_in;
      as_zsign_ff <= as_zsign_in;
      as_spec_ff  <= as_spec_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 32'd0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign status.last_group = last_ff;
   assign rsp_sum_bits      = rsp_ff;

endmodule

// ----- hdl/igsdp_controller.sv -----
module igsdp_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  igsdp_pkg::status_type status,
   output igsdp_pkg::cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_IDLE = 13'b0000000000001,
      ST_DOT  = 13'b0000000000010,
      ST_CONV = 13'b0000000000100,
      ST_MU1  = 13'b0000000001000,
      ST_MM1  = 13'b0000000010000,
      ST_MR1  = 13'b0000000100000,
      ST_MU2  = 13'b0000001000000,
      ST_MM2  = 13'b0000010000000,
      ST_MR2  = 13'b0000100000000,
      ST_AU   = 13'b0001000000000,
      ST_AS   = 13'b0010000000000,
      ST_AR   = 13'b0100000000000,
      ST_EMIT = 13'b1000000000000
   } state_type;

   localparam logic [igsdp_pkg::STEP_W-1:0] LAST_STEP =
      igsdp_pkg::STEP_W'(igsdp_pkg::DOT_STEPS - 1);

   state_type state_ff, state_in;
   logic [igsdp_pkg::STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.dot_idx  = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               state_in   = ST_DOT;
            end
         end
         ST_DOT: begin
            cmd.dot_en = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == LAST_STEP) state_in = ST_CONV;
         end
         ST_CONV: begin
            cmd.conv_en = 1'b1;
            state_in    = ST_MU1;
         end
         ST_MU1: begin
            cmd.mul_unp_en = 1'b1;
            state_in       = ST_MM1;
         end
         ST_MM1: begin
            cmd.mul_mult_en = 1'b1;
            state_in        = ST_MR1;
         end
         ST_MR1: begin
            cmd.mul_rnd_en = 1'b1;
            state_in       = ST_MU2;
         end
         ST_MU2: begin
            cmd.mul_unp_en = 1'b1;
            cmd.mul_sel    = 1'b1;
            state_in       = ST_MM2;
         end
         ST_MM2: begin
            cmd.mul_mult_en = 1'b1;
            state_in        = ST_MR2;
         end
         ST_MR2: begin
            cmd.mul_rnd_en = 1'b1;
            state_in       = ST_AU;
         end
         ST_AU: begin
            cmd.add_unp_en = 1'b1;
            state_in       = ST_AS;
         end
         ST_AS: begin
            cmd.add_sum_en = 1'b1;
            state_in       = ST_AR;
         end
         ST_AR: begin
            cmd.add_rnd_en = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.last_group) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit_en  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/igsdp_checker.sv -----
module igsdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_sum_bits
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a group is in flight");

   a_nan_canonical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sum_bits[30:23] == 8'hFF) && (rsp_sum_bits[22:0] != 23'd0)
      |-> rsp_sum_bits == 32'h7FC00000)
      else $error("non-canonical NaN in response");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind int4_group_scaled_dot_product_core igsdp_checker u_igsdp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_sum_bits (rsp_sum_bits)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   typedef struct {
      logic [63:0] act [4];
      logic [63:0] wlo;
      logic [63:0] whi;
      logic [31:0] act_scale;
      logic [15:0] weight_scale;
      logic        last_group;
   } group_type;

   class sum_scoreboard;
      logic [31:0] acc;
      logic [31:0] sum_q [$];
      int          errors;

      function new();
         acc    = 32'h0;
         errors = 0;
      endfunction

      function real pow2(int n);
         return $bitstoreal({1'b0, 11'(1023 + n), 52'b0});
      endfunction

      function real f32_to_real(logic [31:0] b);
         real r;
         if (b[30:23] == 8'hFF) begin
            r = (b[22:0] != 0) ? $bitstoreal(64'h7FF8000000000000)
                               : $bitstoreal(64'h7FF0000000000000);
         end else if (b[30:23] == 8'h00) begin
            r = real'(b[22:0]) * pow2(-149);
         end else begin
            return $bitstoreal({b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'b0});
         end
         return b[31] ? -r : r;
      endfunction

      function real half_to_real(logic [15:0] h);
         real r;
         if (h[14:10] == 5'd31)
            r = (h[9:0] != 0) ? $bitstoreal(64'h7FF8000000000000)
                              : $bitstoreal(64'h7FF0000000000000);
         else if (h[14:10] == 5'd0)
            r = real'(h[9:0]) * pow2(-24);
         else
            r = real'(1024 + h[9:0]) * pow2(int'(h[14:10]) - 25);
         return h[15] ? -r : r;
      endfunction

      function logic [31:0] real_to_f32(real r);
         logic [63:0] b;
         logic [63:0] mant;
         logic [63:0] q;
         logic [63:0] rem;
         logic        s;
         logic        guard;
         logic        sticky;
         int          ex;
         int          sh;
         b = $realtobits(r);
         s = b[63];
         if (b[62:52] == 11'h7FF)
            return (b[51:0] != 0) ? igsdp_pkg::CANON_NAN : {s, igsdp_pkg::INF_MAG};
         if (b[62:52] == 11'h0)
            return {s, 31'b0};
         ex = int'(b[62:52]) - 1023;
         if (ex > 127)
            return {s, igsdp_pkg::INF_MAG};
         mant = {11'b0, 1'b1, b[51:0]};
         sh   = (ex >= -126) ? 29 : -ex - 97;
         if (sh > 60)
            return {s, 31'b0};
         q      = mant >> sh;
         rem    = mant & ((64'd1 << sh) - 1);
         guard  = rem[sh-1];
         sticky = (rem & ((64'd1 << (sh - 1)) - 1)) != 0;
         if (guard && (sticky || q[0]))
            q = q + 1;
         if (ex < -126)
            return {s, q[30:0]};
         if (q[24]) begin
            q  = q >> 1;
            ex = ex + 1;
         end
         if (ex > 127)
            return {s, igsdp_pkg::INF_MAG};
         return {s, 8'(ex + 127), q[22:0]};
      endfunction

      function int group_dot(group_type g);
         int d;
         int a;
         int w;
         logic [7:0] ab;
         logic [3:0] nb;
         d = 0;
         for (int k = 0; k < igsdp_pkg::ELEMS_USED; k++) begin
            ab = g.act[k / 8][8 * (k % 8) +: 8];
            nb = (k < 16) ? g.wlo[4 * k +: 4] : g.whi[4 * (k - 16) +: 4];
            a  = int'($signed(ab));
            w  = int'(nb) - 8;
            d  = d + a * w;
         end
         return d;
      endfunction

      function void note_request(group_type g);
         logic [31:0] term;
         term = real_to_f32(real'(group_dot(g)) * f32_to_real(g.act_scale));
         term = real_to_f32(f32_to_real(term) * half_to_real(g.weight_scale));
         acc  = real_to_f32(f32_to_real(acc) + f32_to_real(term));
         if (g.last_group) begin
            sum_q.push_back(acc);
            acc = 32'h0;
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_sum(logic [31:0] got);
         logic [31:0] want;
         if (sum_q.size() == 0) begin
            report($sformatf("unexpected sum %h", got));
            return;
         end
         want = sum_q.pop_front();
         if (got !== want)
            report($sformatf("sum_bits %h, want %h", got, want));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_activations_a = '0;
   logic [63:0] req_activations_b = '0;
   logic [63:0] req_activations_c = '0;
   logic [63:0] req_activations_d = '0;
   logic [63:0] req_weight_nibbles_lo = '0;
   logic [63:0] req_weight_nibbles_hi = '0;
   logic [31:0] req_act_scale = '0;
   logic [15:0] req_weight_scale = '0;
   logic        req_last_group = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_sum_bits;

   sum_scoreboard sb = new();
   bit            calm = 1'b0;
   int            quiet_cycles = 0;

   int4_group_scaled_dot_product_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_activations_a     (req_activations_a),
      .req_activations_b     (req_activations_b),
      .req_activations_c     (req_activations_c),
      .req_activations_d     (req_activations_d),
      .req_weight_nibbles_lo (req_weight_nibbles_lo),
      .req_weight_nibbles_hi (req_weight_nibbles_hi),
      .req_act_scale         (req_act_scale),
      .req_weight_scale      (req_weight_scale),
      .req_last_group        (req_last_group),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_sum_bits          (rsp_sum_bits)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_sum(rsp_sum_bits);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= 4000) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_ready <= 1'b0;
            repeat (burst) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic group_type make_group(logic [7:0] a, logic [63:0] wlo,
                                            logic [63:0] whi, logic [31:0] as,
                                            logic [15:0] ws, logic last);
      group_type g;
      for (int i = 0; i < 4; i++)
         g.act[i] = {8{a}};
      g.wlo          = wlo;
      g.whi          = whi;
      g.act_scale    = as;
      g.weight_scale = ws;
      g.last_group   = last;
      return g;
   endfunction

   function automatic group_type random_group();
      group_type g;
      for (int i = 0; i < 4; i++)
         g.act[i] = {$urandom, $urandom};
      g.wlo = {$urandom, $urandom};
      g.whi = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
         g.act_scale    = $urandom;
         g.weight_scale = 16'($urandom);
      end else begin
         g.act_scale    = {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
         g.weight_scale = {1'($urandom), 5'($urandom_range(3, 25)), 10'($urandom)};
      end
      g.last_group = ($urandom_range(0, 3) == 0);
      return g;
   endfunction

   task automatic send_group(group_type g, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_activations_a     <= g.act[0];
      req_activations_b     <= g.act[1];
      req_activations_c     <= g.act[2];
      req_activations_d     <= g.act[3];
      req_weight_nibbles_lo <= g.wlo;
      req_weight_nibbles_hi <= g.whi;
      req_act_scale         <= g.act_scale;
      req_weight_scale      <= g.weight_scale;
      req_last_group        <= g.last_group;
      req_valid             <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(g);
      @(negedge clock);
   endtask

   function automatic int pick_gap();
      if (calm || $urandom_range(0, 5) != 0)
         return 0;
      return $urandom_range(1, 11);
   endfunction

   initial begin
      group_type directed [$];
      group_type g;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_group(8'h80, '0, '0, 32'h3F800000, 16'h3C00, 1'b1));
      directed.push_back(make_group(8'h7F, '0, '0, 32'h3F800000, 16'h3C00, 1'b1));
      directed.push_back(make_group(8'h80, '1, '1, 32'h3F800000, 16'h3C00, 1'b0));
      directed.push_back(make_group(8'h7F, '1, '1, 32'hBF800000, 16'h3C00, 1'b1));
      directed.push_back(make_group(8'h00, '0, '0, 32'h3F800000, 16'h3C00, 1'b1));
      directed.push_back(make_group(8'h01, {16{4'h8}}, {16{4'h8}}, 32'h40000000,
                                    16'h3C00, 1'b1));
      directed.push_back(make_group(8'h55, {16{4'hA}}, {16{4'h5}}, 32'h3F800000,
                                    16'h0001, 1'b1));
      directed.push_back(make_group(8'hAA, {16{4'h3}}, {16{4'hC}}, 32'h3F800000,
                                    16'h83FF, 1'b1));
      directed.push_back(make_group(8'h01, '0, '0, 32'h3F800000, 16'h7C00, 1'b1));
      directed.push_back(make_group(8'h01, '0, '0, 32'h3F800000, 16'hFC00, 1'b1));
      directed.push_back(make_group(8'h01, '0, '0, 32'h3F800000, 16'h7E00, 1'b1));
      directed.push_back(make_group(8'h01, '0, '0, 32'h3F800000, 16'hFC01, 1'b1));
      directed.push_back(make_group(8'h00, '0, '0, 32'h3F800000, 16'h7C00, 1'b1));
      directed.push_back(make_group(8'h01, '0, '0, 32'h7F800000, 16'h3C00, 1'b0));
      directed.push_back(make_group(8'h01, '0, '0, 32'hFF800000, 16'h3C00, 1'b1));
      directed.push_back(make_group(8'h01, '0, '0, 32'h7FC00001, 16'h3C00, 1'b1));
      directed.push_back(make_group(8'h80, '0, '0, 32'h7F7FFFFF, 16'h7BFF, 1'b1));
      directed.push_back(make_group(8'h01, '0, '0, 32'h00000001, 16'h3800, 1'b1));
      directed.push_back(make_group(8'h7F, {16{4'h9}}, {16{4'h9}}, 32'h00800000,
                                    16'h0200, 1'b1));
      directed.push_back(make_group(8'hFF, {16{4'h9}}, {16{4'h9}}, 32'h80000000,
                                    16'h3C00, 1'b1));
      directed.push_back(make_group(8'h80, '0, '0, 32'h4B000000, 16'h3C00, 1'b0));
      directed.push_back(make_group(8'h7F, '0, '0, 32'hCB000000, 16'h3C00, 1'b1));

      foreach (directed[i])
         send_group(directed[i], pick_gap());

      req_valid <= 1'b0;
      while (sb.sum_q.size() != 0)
         @(negedge clock);

      for (int n = 0; n < 550; n++) begin
         if (n == 450)
            calm = 1'b1;
         g = random_group();
         send_group(g, pick_gap());
      end
      g = random_group();
      g.last_group = 1'b1;
      send_group(g, 0);
      req_valid <= 1'b0;

      while (sb.sum_q.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
